// File: rtl/sbsp_pkg.sv
// ----------------------------------------------------------------------------
// sbsp_pkg
// Shared widths, item kind codes and state type of the stretch player.
// ----------------------------------------------------------------------------
package sbsp_pkg;

  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int IDX_W       = ADDR_W + 1;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = IDX_W + FRAC_W;
  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 24;
  localparam int KIND_W      = 3;
  localparam int PROD_W      = SAMPLE_W + FRAC_W + 2;
  localparam int SUM_W       = SAMPLE_W + 3;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // position saturates at store depth in fixed point
  localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [POS_W-1:0] POS_HALF  = POS_W'(1) << (FRAC_W - 1);

  localparam logic [KIND_W-1:0] KIND_WRITE_AT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ_AT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_NEXT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_STR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REWIND    = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL
  } state_t;

endpackage

// File: rtl/sbsp_ram.sv
// ----------------------------------------------------------------------------
// sbsp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sample_buffer_stretch_player_core.sv
// ----------------------------------------------------------------------------
// sample_buffer_stretch_player_core
// Sample store with a play cursor, indexed and stretched playback.
// ----------------------------------------------------------------------------
// An item is taken when the block is idle and the result register is free or
// being emptied. Its result is loaded from the READ state after the sample
// memory's registered read, or for an interpolating stretched read from the
// MUL state after the registered interpolation multiply; no new item is taken
// meanwhile. The store needs no clearing after reset if entries are read only
// after they are written; the user keeps to it, the block does not enforce it.
// Writing active_length rewinds the cursor and must happen while idle.
module sample_buffer_stretch_player_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sbsp_pkg::IDX_W-1:0]       cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // kind[2:0], index[14:3], sample_in[30:15], step_factor[54:31], zero[55]
  input  logic [sbsp_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample_out[15:0], cursor[28:16], at_end[29], zero[31:30]
  output logic [sbsp_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import sbsp_pkg::*;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]  len_r;
  logic [IDX_W-1:0]  pi_r, pi_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic [KIND_W-1:0]          kind_r;
  logic                       rd_ok_r;
  logic                       interp_r;
  logic signed [FRAC_W:0]     frac_r;
  logic signed [SAMPLE_W-1:0] s0_r;
  logic signed [PROD_W-1:0]   prod_r;

  logic                       out_tvalid_r;
  logic [SAMPLE_W-1:0]        out_sample_r;

  // input fields
  logic [KIND_W-1:0]   in_kind;
  logic [ADDR_W-1:0]   in_index;
  logic [SAMPLE_W-1:0] in_sample;
  logic [STEP_W-1:0]   in_step;

  assign in_kind   = in_tdata[KIND_W-1:0];
  assign in_index  = in_tdata[KIND_W +: ADDR_W];
  assign in_sample = in_tdata[KIND_W+ADDR_W +: SAMPLE_W];
  assign in_step   = in_tdata[KIND_W+ADDR_W+SAMPLE_W +: STEP_W];

  logic in_fire;
  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // memory ports, two mirrored copies give cursor and cursor + 1 together
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   rd0_addr, rd1_addr;
  logic [SAMPLE_W-1:0] rd0_data, rd1_data;

  logic idx_ok, pi_ok;
  assign idx_ok = {1'b0, in_index} < len_r;
  assign pi_ok  = pi_r < len_r;

  assign ram_we    = in_fire && (((in_kind == KIND_WRITE_AT) && idx_ok) ||
                                 ((in_kind == KIND_APPEND) && pi_ok));
  assign ram_waddr = (in_kind == KIND_WRITE_AT) ? in_index : pi_r[ADDR_W-1:0];
  assign rd0_addr  = (in_kind == KIND_READ_AT) ? in_index : pi_r[ADDR_W-1:0];
  assign rd1_addr  = pi_r[ADDR_W-1:0] + ADDR_W'(1);

  sbsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sample),
    .raddr (rd0_addr),
    .rdata (rd0_data)
  );

  sbsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sample),
    .raddr (rd1_addr),
    .rdata (rd1_data)
  );

  // cursor update at acceptance
  logic [POS_W:0]    pos_sum;
  logic [POS_W-1:0]  pos_sat;
  logic [POS_W-1:0]  pos_rnd;
  logic [IDX_W-1:0]  pi_inc;
  logic [POS_W-1:0]  frac_full;
  logic              interp_ok;

  assign pos_sum   = {1'b0, pos_r} + (POS_W+1)'(in_step);
  assign pos_sat   = (pos_sum > {1'b0, POS_LIMIT}) ? POS_LIMIT : pos_sum[POS_W-1:0];
  assign pos_rnd   = pos_sat + POS_HALF;
  assign pi_inc    = pi_r + IDX_W'(1);
  assign frac_full = pos_r - {pi_r, {FRAC_W{1'b0}}};
  assign interp_ok = (in_step[STEP_W-1:FRAC_W] == '0) &&
                     (({1'b0, pi_r} + (IDX_W+1)'(2)) < {1'b0, len_r});

  always_comb begin
    pi_nxt  = pi_r;
    pos_nxt = pos_r;
    unique case (in_kind)
      KIND_APPEND, KIND_READ_NEXT: begin
        if (pi_ok) begin
          pi_nxt  = pi_inc;
          pos_nxt = {pi_inc, {FRAC_W{1'b0}}};
        end
      end
      KIND_READ_STR: begin
        if (pi_ok) begin
          pos_nxt = pos_sat;
          pi_nxt  = pos_rnd[POS_W-1:FRAC_W];
        end
      end
      KIND_REWIND: begin
        pi_nxt  = '0;
        pos_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= IDX_W'(STORE_DEPTH);
      pi_r  <= '0;
      pos_r <= '0;
    end else if (cfg_wr_en) begin
      len_r <= (cfg_wr_data > IDX_W'(STORE_DEPTH)) ? IDX_W'(STORE_DEPTH) : cfg_wr_data;
      pi_r  <= '0;
      pos_r <= '0;
    end else if (in_fire) begin
      pi_r  <= pi_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_kind;
      rd_ok_r  <= (in_kind == KIND_READ_AT) ? idx_ok : pi_ok;
      interp_r <= interp_ok;
      frac_r   <= frac_full[FRAC_W:0];
    end
  end

  // interpolation datapath
  logic signed [SAMPLE_W-1:0] s0, s1;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0]        sat_sample;

  assign s0       = signed'(rd0_data);
  assign s1       = signed'(rd1_data);
  assign diff     = (SAMPLE_W+1)'(s1) - (SAMPLE_W+1)'(s0);
  assign prod     = diff * frac_r;
  assign prod_rnd = (prod_r + signed'(PROD_W'(POS_HALF))) >>> FRAC_W;
  assign sum      = SUM_W'(s0_r) + SUM_W'(signed'(prod_rnd[SAMPLE_W+1:0]));

  always_comb begin
    priority if (sum > SUM_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
      sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sum < -SUM_W'(signed'({1'b0, 1'b1, {(SAMPLE_W-1){1'b0}}}))) begin
      sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_sample = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      s0_r   <= s0;
      prod_r <= prod;
    end
  end

  // control
  logic                out_load;
  logic [SAMPLE_W-1:0] out_sample_nxt;

  always_comb begin
    state_nxt      = state_r;
    out_load       = 1'b0;
    out_sample_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if ((kind_r == KIND_READ_STR) && rd_ok_r && interp_r) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
          out_load  = 1'b1;
          if (rd_ok_r && ((kind_r == KIND_READ_AT) || (kind_r == KIND_READ_NEXT) ||
                          (kind_r == KIND_READ_STR))) begin
            out_sample_nxt = rd0_data;
          end
        end
      end
      ST_MUL: begin
        state_nxt      = ST_IDLE;
        out_load       = 1'b1;
        out_sample_nxt = sat_sample;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  // cursor/length only change on acceptance or config writes (user keeps idle)
  logic at_end;
  assign at_end = (len_r == '0) || (pi_r >= len_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W-SAMPLE_W-IDX_W-1)'(0), at_end, pi_r, out_sample_r};

`ifndef ASSERT_OFF
  a_fire_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_READ))
    else $error("accepted item did not start a memory read");

  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_tvalid_r)
    else $error("result register busy while an item is in flight");

  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_READ) && !interp_r) |=> out_tvalid_r)
    else $error("plain read did not produce a result");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    pi_r <= IDX_W'(STORE_DEPTH))
    else $error("cursor beyond store depth");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("position beyond saturation limit");
`endif

endmodule

// File: tb/tb_sample_buffer_stretch_player_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_buffer_stretch_player_core
// Drives command items into the stretch player and checks every result item
// against a cycle-free model of the store, cursor and stretched playback.
// A directed opener covers the range edges, interpolation saturation and the
// end-of-buffer cases; random runs of appends, plays, stretched reads and
// indexed accesses follow under a series of active lengths.
// ----------------------------------------------------------------------------
module tb_sample_buffer_stretch_player_core;
  import sbsp_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 7;
  localparam int MAX_GAP         = 17;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_PHASE      = 7;
  localparam int PHASE_COUNT     = 12;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_REPORTS     = 10;
  localparam int TIMEOUT_NS      = 10_000_000;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_W;
  localparam longint Q15_MAX = 32767;
  localparam longint Q15_MIN = -32768;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] pcm;
    logic [STEP_W-1:0]          step;
  } play_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic [IDX_W-1:0]           cursor;
    logic                       at_end;
  } play_out_t;

  typedef enum {RUN_FILL, RUN_PLAY, RUN_STRETCH, RUN_ACCESS, RUN_NOISE} run_mode_e;

  class playback_scoreboard;
    logic signed [SAMPLE_W-1:0] store [STORE_DEPTH];
    bit                         written [STORE_DEPTH];
    logic [IDX_W-1:0]           act_len;
    logic [IDX_W-1:0]           cur_idx;
    logic [POS_W-1:0]           cur_pos;
    play_out_t                  expected_outs [$];
    int                         errors;

    function new();
      act_len = IDX_W'(STORE_DEPTH);
      errors  = 0;
      rewind();
    endfunction

    function void rewind();
      cur_idx = '0;
      cur_pos = '0;
    endfunction

    function void set_length(logic [IDX_W-1:0] value);
      act_len = (value > STORE_DEPTH) ? IDX_W'(STORE_DEPTH) : value;
      rewind();
    endfunction

    function int pending();
      return expected_outs.size();
    endfunction

    // slow stretched read away from the end blends with the following sample
    function bit blends(logic [STEP_W-1:0] step);
      return step < STEP_ONE && act_len >= 2 && int'(cur_idx) + 1 < int'(act_len) - 1;
    endfunction

    // store entry a command would read before it was ever written, or -1
    function int unwritten_entry(play_cmd_t c);
      int pos_i;
      pos_i = int'(cur_idx);
      case (c.kind)
        KIND_READ_AT: begin
          if (c.addr < act_len && !written[c.addr]) return int'(c.addr);
        end
        KIND_READ_NEXT, KIND_READ_STR: begin
          if (cur_idx < act_len) begin
            if (!written[pos_i]) return pos_i;
            if (c.kind == KIND_READ_STR && blends(c.step) && !written[pos_i + 1])
              return pos_i + 1;
          end
        end
        default: ;
      endcase
      return -1;
    endfunction

    function void note_command(play_cmd_t c);
      play_out_t  r;
      longint     s0;
      longint     s1;
      longint     frac;
      longint     acc;
      logic [31:0] pos_next;
      r = '0;
      case (c.kind)
        KIND_WRITE_AT: begin
          if (c.addr < act_len) begin
            store[c.addr]   = c.pcm;
            written[c.addr] = 1'b1;
          end
        end
        KIND_READ_AT: begin
          if (c.addr < act_len) r.pcm = store[c.addr];
        end
        KIND_APPEND, KIND_READ_NEXT: begin
          if (cur_idx < act_len) begin
            if (c.kind == KIND_APPEND) begin
              store[cur_idx]   = c.pcm;
              written[cur_idx] = 1'b1;
            end else begin
              r.pcm = store[cur_idx];
            end
            cur_idx = cur_idx + 1'b1;
            cur_pos = POS_W'(cur_idx) << FRAC_W;
          end
        end
        KIND_READ_STR: begin
          if (cur_idx < act_len) begin
            s0 = store[cur_idx];
            if (blends(c.step)) begin
              s1 = store[int'(cur_idx) + 1];
              // fraction goes negative when the index was rounded up
              frac = longint'(cur_pos) - (longint'(cur_idx) << FRAC_W);
              acc = s0 + (((s1 - s0) * frac + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W);
              if (acc > Q15_MAX) r.pcm = SAMPLE_W'(Q15_MAX);
              else if (acc < Q15_MIN) r.pcm = SAMPLE_W'(Q15_MIN);
              else r.pcm = acc[SAMPLE_W-1:0];
            end else begin
              r.pcm = s0[SAMPLE_W-1:0];
            end
            pos_next = 32'(cur_pos) + 32'(c.step);
            if (pos_next > 32'(POS_LIMIT)) pos_next = 32'(POS_LIMIT);
            cur_pos = pos_next[POS_W-1:0];
            cur_idx = IDX_W'((pos_next + 32'(POS_HALF)) >> FRAC_W);
          end
        end
        KIND_REWIND: rewind();
        default: ;
      endcase
      r.cursor = cur_idx;
      r.at_end = (act_len == 0) || (cur_idx >= act_len);
      expected_outs.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      play_out_t got;
      play_out_t want;
      got.pcm    = word[15:0];
      got.cursor = word[28:16];
      got.at_end = word[29];
      if (expected_outs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with nothing expected: pcm %0d cursor %0d at_end %b",
                   $time, got.pcm, got.cursor, got.at_end);
        return;
      end
      want = expected_outs.pop_front();
      if (got.pcm !== want.pcm || got.cursor !== want.cursor || got.at_end !== want.at_end) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: expected pcm %0d cursor %0d at_end %b, got pcm %0d cursor %0d at_end %b",
                   $time, want.pcm, want.cursor, want.at_end, got.pcm, got.cursor, got.at_end);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [IDX_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  playback_scoreboard sb;
  logic [IDX_W-1:0]   phase_lengths [PHASE_COUNT];
  bit                 hold_off;
  bit                 tx_calm;
  bit                 rx_calm;
  run_mode_e          run_mode;
  int                 run_left;
  int                 step_band;

  sample_buffer_stretch_player_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic play_cmd_t make_cmd(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                         logic [SAMPLE_W-1:0] pcm, logic [STEP_W-1:0] step);
    play_cmd_t c;
    c.kind = kind;
    c.addr = addr;
    c.pcm  = pcm;
    c.step = step;
    return c;
  endfunction

  // runs of well-formed playback with random content, some noise in between
  function automatic play_cmd_t next_command();
    play_cmd_t c;
    int        hole;
    int        lo;
    if (run_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1:    run_mode = RUN_FILL;
        2, 3:    run_mode = RUN_PLAY;
        4, 5, 6: run_mode = RUN_STRETCH;
        7, 8:    run_mode = RUN_ACCESS;
        default: run_mode = RUN_NOISE;
      endcase
      step_band = $urandom_range(0, 3);
      // fast sweeps need many items to reach the saturated position
      run_left = (run_mode == RUN_STRETCH && step_band == 3) ? 48 : $urandom_range(1, 20);
    end
    run_left--;
    c.kind = KIND_REWIND;
    c.addr = ADDR_W'($urandom);
    case ($urandom_range(0, 7))
      0:       c.pcm = SAMPLE_W'(Q15_MAX);
      1:       c.pcm = SAMPLE_W'(Q15_MIN);
      2:       c.pcm = '0;
      default: c.pcm = SAMPLE_W'($urandom);
    endcase
    c.step = STEP_W'($urandom);
    case (run_mode)
      RUN_FILL: c.kind = KIND_APPEND;
      RUN_PLAY: c.kind = KIND_READ_NEXT;
      RUN_STRETCH: begin
        c.kind = KIND_READ_STR;
        case (step_band)
          0: begin
            case ($urandom_range(0, 5))
              0:       c.step = '0;
              1:       c.step = STEP_ONE >> 1;
              2:       c.step = STEP_ONE - 1'b1;
              default: c.step = STEP_W'($urandom_range(0, 32'(STEP_ONE) - 1));
            endcase
          end
          1: c.step = STEP_W'($urandom_range(24'h00E000, 24'h012000));
          2: c.step = STEP_W'($urandom_range(24'h010000, 24'h080000));
          default: begin
            if ($urandom_range(0, 1) == 1) c.step = '1;
          end
        endcase
      end
      RUN_ACCESS: begin
        c.kind = $urandom_range(0, 1) ? KIND_READ_AT : KIND_WRITE_AT;
        if (sb.act_len != 0 && $urandom_range(0, 7) != 0) begin
          lo = (sb.cur_idx > 16) ? int'(sb.cur_idx) - 16 : 0;
          if ($urandom_range(0, 1) == 1)
            c.addr = ADDR_W'($urandom_range(0, int'(sb.act_len) - 1));
          else
            c.addr = ADDR_W'($urandom_range(lo, lo + 15));
        end
      end
      default: c.kind = KIND_W'($urandom_range(0, 7));
    endcase
    if ((run_mode == RUN_FILL || run_mode == RUN_PLAY || run_mode == RUN_STRETCH)
        && sb.cur_idx >= sb.act_len && $urandom_range(0, 1) == 1)
      c.kind = KIND_REWIND;
    // never read an entry before it holds data: fill it instead
    hole = sb.unwritten_entry(c);
    if (hole >= 0) begin
      c.kind = KIND_WRITE_AT;
      c.addr = ADDR_W'(hole);
    end
    return c;
  endfunction

  task automatic send_command(input play_cmd_t c);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = (tx_calm || hold_off) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {1'b0, c.step, c.pcm, c.addr, c.kind};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_command(c);
    @(negedge clk);
  endtask

  // every item yields a result, so an empty queue means the block is idle
  task automatic write_length(input logic [IDX_W-1:0] value);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_length(value);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    hold_off    = 1'b0;
    tx_calm     = 1'b0;
    run_left    = 0;
    sb = new();
    phase_lengths = '{13'd8191, 13'd0, 13'd1, 13'd2, 13'd3, 13'd6,
                      13'd4097, 13'd300, 13'd4096, 13'd9, 13'd1000, 13'd64};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // full length after reset: edges, interpolation saturating both ways
    send_command(make_cmd(KIND_WRITE_AT, 12'd0, 16'h7FFF, '0));
    send_command(make_cmd(KIND_WRITE_AT, 12'd1, 16'h7FFF, '0));
    send_command(make_cmd(KIND_WRITE_AT, 12'd2, 16'h8000, '0));
    send_command(make_cmd(KIND_WRITE_AT, 12'd3, 16'h7FFF, '0));
    send_command(make_cmd(KIND_WRITE_AT, 12'd4095, 16'hFFFF, '0));
    send_command(make_cmd(KIND_READ_AT, 12'd4095, '0, '0));
    send_command(make_cmd(KIND_READ_AT, 12'd0, '0, '0));
    send_command(make_cmd(KIND_READ_STR, '0, '0, STEP_ONE >> 1));
    send_command(make_cmd(KIND_READ_STR, '0, '0, STEP_ONE >> 1));
    send_command(make_cmd(KIND_READ_STR, '0, '0, STEP_ONE >> 1));
    send_command(make_cmd(KIND_READ_STR, '0, '0, '0));
    send_command(make_cmd(KIND_READ_STR, '0, '0, STEP_ONE - 1'b1));
    send_command(make_cmd(KIND_READ_STR, '0, '0, STEP_ONE));
    send_command(make_cmd(KIND_APPEND, '0, 16'h5A5A, '0));
    send_command(make_cmd(KIND_REWIND, '0, '0, '0));
    send_command(make_cmd(KIND_READ_NEXT, '0, '0, '0));
    send_command(make_cmd(KIND_SPARE_A, '1, '1, '1));
    send_command(make_cmd(KIND_SPARE_B, '0, '0, '0));

    // short buffer: out of range accesses and running off the end
    write_length(13'd2);
    send_command(make_cmd(KIND_WRITE_AT, 12'd2, 16'h0001, '0));
    send_command(make_cmd(KIND_READ_AT, 12'd2, '0, '0));
    send_command(make_cmd(KIND_APPEND, '0, 16'h0064, '0));
    send_command(make_cmd(KIND_APPEND, '0, 16'hFF9C, '0));
    send_command(make_cmd(KIND_APPEND, '0, 16'h0007, '0));
    send_command(make_cmd(KIND_READ_NEXT, '0, '0, '0));
    send_command(make_cmd(KIND_READ_STR, '0, '0, STEP_ONE >> 1));

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_length(phase_lengths[p]);
      // receiver holds off while items keep coming, filling the block
      if (p == HOLD_PHASE) hold_off = 1'b1;
      repeat (ITEMS_PER_PHASE) send_command(next_command());
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    rx_calm    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
